// File: design/sra_pkg.sv
// ----------------------------------------------------------------------------
// sra_pkg: shared types for the shelf rectangle allocator
// Request/response payloads, coordinate width and sequencer state codes.
// ----------------------------------------------------------------------------
package sra_pkg;

	localparam int unsigned SIZE_W  = 16;
	localparam int unsigned COORD_W = 11;

	typedef struct packed {
		logic [SIZE_W-1:0] rect_width;
		logic [SIZE_W-1:0] rect_height;
	} req_t;

	typedef struct packed {
		logic               placed;
		logic [COORD_W-1:0] place_x;
		logic [COORD_W-1:0] place_y;
	} rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SIZE = 5'b00010,
		ST_SCAN = 5'b00100,
		ST_NEW  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

endpackage

// File: design/shelf_rectangle_allocator_core.sv
// ----------------------------------------------------------------------------
// shelf_rectangle_allocator_core: first-fit shelf packing in a square atlas
//
//   channel | signals                         | payload
//   --------+---------------------------------+-------------------------------
//   request | req_valid / req_ready / req_data| rect_width, rect_height
//   result  | rsp_valid / rsp_ready / rsp_data| placed, place_x, place_y
//
// Each accepted request scans the open shelves in order from shelf 0 and
// tries to open a new shelf when none of them takes it; the shelf table is
// one RAM read port, scanned one shelf per cycle through a single shared
// add-and-compare unit. Oversized requests skip the scan and go straight
// to the result. arst_n clears the sequencer and the shelf count; the
// shelf table itself is never cleared.
// A stalled result holds the block in its final state until taken.
// ----------------------------------------------------------------------------
module shelf_rectangle_allocator_core
	import sra_pkg::*;
#(
	parameter int unsigned ATLAS_SIDE  = 2048,
	parameter int unsigned SHELF_SLOTS = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp_data
);

	localparam int unsigned CW = $clog2(ATLAS_SIDE + 1);
	localparam int unsigned SW = $clog2(SHELF_SLOTS + 1);
	localparam int unsigned AW = (SHELF_SLOTS > 1) ? $clog2(SHELF_SLOTS) : 1;
	localparam int unsigned EW = 3 * CW;
	localparam int unsigned PW = SIZE_W + 1;
	localparam int unsigned XW = (CW + 1 > COORD_W) ? CW + 1 : COORD_W;

	state_t          state_q;
	logic [PW-1:0]   pw_q, ph_q;
	logic [SW-1:0]   open_q;
	logic [CW-1:0]   next_y_q;
	logic [SW-1:0]   rd_idx_q;
	logic            chk_vld_s1;
	logic [AW-1:0]   chk_idx_s1;
	rsp_t            pend_q;
	rsp_t            rsp_q;
	logic            rsp_vld_q;

	logic            we;
	logic [AW-1:0]   waddr;
	logic [EW-1:0]   wdata;
	logic [EW-1:0]   rdata;

	logic [CW-1:0]   ent_fill, ent_top, ent_h;
	logic [CW-1:0]   pw, ph;
	logic [CW-1:0]   op_a, op_b;
	logic [CW:0]     sum;
	logic            room;
	logic            fit;
	logic            issue;
	logic            new_ok;
	logic            oversize;
	logic            out_free;
	logic [XW-1:0]   x_ext, y_ext;

	sra_ram #(
		.WIDTH(EW),
		.DEPTH(SHELF_SLOTS)
	) u_shelf_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(rd_idx_q[AW-1:0]),
		.rdata(rdata)
	);

	assign ent_fill = rdata[3*CW-1:2*CW];
	assign ent_top  = rdata[2*CW-1:CW];
	assign ent_h    = rdata[CW-1:0];
	assign pw       = pw_q[CW-1:0];
	assign ph       = ph_q[CW-1:0];

	assign oversize = (pw_q > PW'(ATLAS_SIDE)) || (ph_q > PW'(ATLAS_SIDE));

	// shared adder: shelf fill + width while scanning, running top + height on open
	always_comb begin
		op_a = (state_q == ST_SCAN) ? ent_fill : next_y_q;
		op_b = (state_q == ST_SCAN) ? pw : ph;
		sum  = {1'b0, op_a} + {1'b0, op_b};
		room = (sum <= (CW+1)'(ATLAS_SIDE));
	end

	assign fit      = chk_vld_s1 && room && (ph <= ent_h);
	assign issue    = (rd_idx_q < open_q) && !fit;
	assign new_ok   = (open_q < SW'(SHELF_SLOTS)) && room;
	assign out_free = !rsp_vld_q || rsp_ready;

	always_comb begin
		we    = 1'b0;
		waddr = chk_idx_s1;
		wdata = {sum[CW-1:0], ent_top, ent_h};
		x_ext = XW'(ent_fill) + XW'(1);
		y_ext = XW'(ent_top) + XW'(1);
		case (state_q)
			ST_SCAN: begin
				we = fit;
			end
			ST_NEW: begin
				we    = new_ok;
				waddr = open_q[AW-1:0];
				wdata = {pw, next_y_q, ph};
				x_ext = XW'(1);
				y_ext = XW'(next_y_q) + XW'(1);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			open_q     <= '0;
			next_y_q   <= '0;
			rd_idx_q   <= '0;
			chk_vld_s1 <= 1'b0;
			chk_idx_s1 <= '0;
			rsp_vld_q  <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp_vld_q && rsp_ready) begin
				rsp_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_SIZE;
					end
				end
				ST_SIZE: begin
					rd_idx_q   <= '0;
					chk_vld_s1 <= 1'b0;
					state_q    <= oversize ? ST_DONE : ST_SCAN;
				end
				ST_SCAN: begin
					chk_vld_s1 <= issue;
					if (issue) begin
						rd_idx_q   <= rd_idx_q + SW'(1);
						chk_idx_s1 <= rd_idx_q[AW-1:0];
					end
					if (fit) begin
						state_q <= ST_DONE;
					end else if (!issue && !chk_vld_s1) begin
						state_q <= ST_NEW;
					end
				end
				ST_NEW: begin
					if (new_ok) begin
						open_q   <= open_q + SW'(1);
						next_y_q <= sum[CW-1:0];
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			pw_q <= PW'(req_data.rect_width) + PW'(2);
			ph_q <= PW'(req_data.rect_height) + PW'(2);
		end
		if (state_q == ST_SIZE) begin
			pend_q <= '0;
		end
		if ((state_q == ST_SCAN && fit) || (state_q == ST_NEW && new_ok)) begin
			pend_q.placed  <= 1'b1;
			pend_q.place_x <= x_ext[COORD_W-1:0];
			pend_q.place_y <= y_ext[COORD_W-1:0];
		end
		if (state_q == ST_DONE && out_free) begin
			rsp_q <= pend_q;
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_vld_q;
	assign rsp_data  = rsp_q;

endmodule

// File: design/sra_ram.sv
// ----------------------------------------------------------------------------
// sra_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sra_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/sra_checker.sv
// ----------------------------------------------------------------------------
// sra_checker: port-level checks for the shelf rectangle allocator
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module sra_checker
	import sra_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req_data,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	// a waiting request holds
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req_data))
		else $error("request changed while waiting");

	// a failed request reports a zero origin
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.placed |-> rsp_data.place_x == '0 && rsp_data.place_y == '0)
		else $error("failed request with nonzero origin");

	// one request at a time: busy right after taking one
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	// interior origin sits inside the border, never on row or column zero
	a_placed_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.placed |-> rsp_data.place_x != '0 && rsp_data.place_y != '0)
		else $error("placed rectangle on the atlas edge");

endmodule

bind shelf_rectangle_allocator_core sra_checker u_sra_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req_data (req_data),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp_data (rsp_data)
);

// File: tb/sv/shelf_rectangle_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// shelf_rectangle_allocator_core_tb: self-checking bench for the shelf allocator
// Drives rectangle requests with random gaps on both handshakes. A tracker
// keeps its own copy of the shelf table and predicts each placement, then
// compares every returned result with the oldest prediction. Stimulus runs
// from edge sizes through mixed random traffic to filling every shelf slot.
// ----------------------------------------------------------------------------
module shelf_rectangle_allocator_core_tb;
	import sra_pkg::*;

	localparam int unsigned ATLAS_SIDE   = 2048;
	localparam int unsigned SHELF_SLOTS  = 64;
	localparam int unsigned RANDOM_REQS  = 1200;
	localparam int unsigned CYCLE_LIMIT  = 1500000;
	localparam int unsigned HOLD_AT      = 250;
	localparam int unsigned HOLD_CYCLES  = 500;
	localparam int unsigned DRAIN_CYCLES = 80;

	class atlas_tracker;
		logic [11:0]  fill_x [SHELF_SLOTS];
		logic [11:0]  top_y [SHELF_SLOTS];
		logic [11:0]  shelf_h [SHELF_SLOTS];
		int unsigned  open_cnt;
		int unsigned  next_y;
		int unsigned  errors;
		rsp_t         placements_due[$];

		function new();
			open_cnt = 0;
			next_y   = 0;
			errors   = 0;
		endfunction

		// predict where an accepted request lands and update the shelf table
		function void place_request(req_t r);
			int unsigned pw;
			int unsigned ph;
			int unsigned s;
			bit          done;
			rsp_t        want;
			pw   = 32'(r.rect_width) + 2;
			ph   = 32'(r.rect_height) + 2;
			done = 1'b0;
			want = '0;
			if (pw <= ATLAS_SIDE && ph <= ATLAS_SIDE) begin
				for (s = 0; s < open_cnt && !done; s++) begin
					if (ph <= shelf_h[s] && 32'(fill_x[s]) + pw <= ATLAS_SIDE) begin
						want.placed  = 1'b1;
						want.place_x = COORD_W'(32'(fill_x[s]) + 1);
						want.place_y = COORD_W'(32'(top_y[s]) + 1);
						fill_x[s]    = 12'(32'(fill_x[s]) + pw);
						done         = 1'b1;
					end
				end
				if (!done && open_cnt < SHELF_SLOTS && next_y + ph <= ATLAS_SIDE) begin
					top_y[open_cnt]   = 12'(next_y);
					shelf_h[open_cnt] = 12'(ph);
					fill_x[open_cnt]  = 12'(pw);
					open_cnt++;
					want.placed  = 1'b1;
					want.place_x = COORD_W'(1);
					want.place_y = COORD_W'(next_y + 1);
					next_y += ph;
				end
			end
			placements_due.push_back(want);
		endfunction

		function void check_placement(rsp_t got);
			rsp_t want;
			if (placements_due.size() == 0) begin
				$error("result with no request pending: placed=%0d x=%0d y=%0d",
					got.placed, got.place_x, got.place_y);
				errors++;
				return;
			end
			want = placements_due.pop_front();
			if (got.placed !== want.placed) begin
				$error("placed: expected %0d, got %0d", want.placed, got.placed);
				errors++;
			end
			if (got.place_x !== want.place_x) begin
				$error("place_x: expected %0d, got %0d", want.place_x, got.place_x);
				errors++;
			end
			if (got.place_y !== want.place_y) begin
				$error("place_y: expected %0d, got %0d", want.place_y, got.place_y);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req_data;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp_data;

	atlas_tracker tracker;
	int unsigned  cycles;
	int unsigned  results_taken;
	int           req_calm;
	int           rsp_calm;

	shelf_rectangle_allocator_core #(
		.ATLAS_SIDE  (ATLAS_SIDE),
		.SHELF_SLOTS (SHELF_SLOTS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("shelf_rectangle_allocator_core_tb NOT OK");
			$finish;
		end
	end

	// mostly short gaps, a few long ones, and now and then a calm stretch
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3)
			calm = $urandom_range(20, 60);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(30, 90);
	endfunction

	// valid stays up across back-to-back requests; dropped only ahead of a gap
	task automatic send_req(input int unsigned w, input int unsigned h);
		req_t r;
		int   gap;
		r.rect_width  = SIZE_W'(w);
		r.rect_height = SIZE_W'(h);
		gap = pick_gap(req_calm);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_data  <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		tracker.place_request(r);
	endtask

	task automatic send_random_req();
		int unsigned r;
		int unsigned w;
		int unsigned h;
		r = $urandom_range(0, 99);
		if (r < 78) begin
			w = $urandom_range(0, 62);
			h = $urandom_range(0, 30);
		end else if (r < 88) begin
			w = $urandom_range(0, 400);
			h = $urandom_range(0, 100);
		end else if (r < 92) begin
			// near full width, fits only on a shelf with little fill
			w = $urandom_range(1500, 2046);
			h = $urandom_range(0, 14);
		end else if (r < 95) begin
			w = $urandom_range(0, 2046);
			h = $urandom_range(0, 300);
		end else if (r < 97) begin
			// as tall as the vertical room left, or just taller
			w = $urandom_range(0, 2046);
			h = (ATLAS_SIDE - 2 > tracker.next_y) ? ATLAS_SIDE - 2 - tracker.next_y : 0;
			h = h + $urandom_range(0, 50);
		end else begin
			w = $urandom_range(0, 65535);
			h = $urandom_range(0, 65535);
		end
		send_req(w, h);
	endtask

	initial begin : result_side
		int idle_left;
		bit held;
		rsp_ready     = 1'b0;
		rsp_calm      = 0;
		results_taken = 0;
		idle_left     = 0;
		held          = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready) begin
				tracker.check_placement(rsp_data);
				results_taken++;
			end
			// one long hold-off so the block backs up onto the request side
			if (!held && results_taken == HOLD_AT) begin
				held      = 1'b1;
				idle_left = HOLD_CYCLES;
			end
			if (idle_left > 0) begin
				idle_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
				idle_left = pick_gap(rsp_calm);
			end
		end
	end

	initial begin : request_side
		int unsigned room;
		tracker   = new();
		cycles    = 0;
		req_calm  = 0;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req_data  = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// edge sizes
		send_req(0, 0);
		send_req(0, 0);
		send_req(65535, 65535);
		send_req(65534, 0);
		send_req(0, 65534);
		send_req(2047, 0);
		send_req(0, 2047);
		send_req(2046, 0);
		send_req(10, 30);
		send_req(5, 5);
		send_req(0, 0);
		send_req(2030, 0);
		send_req(10, 0);
		send_req(0, 2046);
		send_req(0, 2011);
		send_req(65535, 0);
		send_req(0, 65535);

		repeat (RANDOM_REQS) send_random_req();

		// full-width strips open a shelf each until one slot is left or the vertical room runs short
		while (tracker.open_cnt < SHELF_SLOTS - 1 && tracker.next_y + 4 <= ATLAS_SIDE)
			send_req(2046, 0);
		if (tracker.next_y + 2 <= ATLAS_SIDE) begin
			room = ATLAS_SIDE - tracker.next_y;
			send_req(2046, room - 1);
			send_req(2046, room - 2);
		end
		send_req(2046, 0);
		send_req(0, 0);
		req_valid <= 1'b0;

		while (tracker.placements_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0)
			$display("shelf_rectangle_allocator_core_tb OK");
		else
			$display("shelf_rectangle_allocator_core_tb NOT OK");
		$finish;
	end

endmodule
